FILE: hdl/ps2m_pkg.sv
// Shared types and constants for the PS/2 mouse packet event decoder.
// Used by ps2m_step, ps2m_rq and ps2_mouse_packet_event_decoder_core.
package ps2m_pkg;

    localparam int unsigned SCREEN_WIDTH  = 800;
    localparam int unsigned SCREEN_HEIGHT = 600;

    localparam logic [31:0] POS_X_RESET = 32'(SCREEN_WIDTH / 2);
    localparam logic [31:0] POS_Y_RESET = 32'(SCREEN_HEIGHT / 2);
    localparam logic [31:0] STAMP_IDLE  = 32'hFFFF_FC18;   // -1000

    localparam logic [15:0] MOVE_GAP_RESET     = 16'd5;
    localparam logic [15:0] CLICK_WINDOW_RESET = 16'd30;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_ID    = 2'd0;
    localparam logic [1:0] REG_MOVE_GAP     = 2'd1;
    localparam logic [1:0] REG_CLICK_WINDOW = 2'd2;

    // position of the next byte within a packet
    localparam logic [2:0] IDX_HEADER = 3'd0;
    localparam logic [2:0] IDX_X      = 3'd1;
    localparam logic [2:0] IDX_Y      = 3'd2;
    localparam logic [2:0] IDX_WHEEL  = 3'd3;

    localparam logic [7:0] DEV_STANDARD = 8'd0;
    localparam logic [7:0] DEV_WHEEL    = 8'd3;
    localparam logic [7:0] DEV_WHEEL5   = 8'd4;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_SCROLL = 3'd1;
    localparam logic [2:0] EV_MOVE   = 3'd2;
    localparam logic [2:0] EV_DOWN   = 3'd3;
    localparam logic [2:0] EV_UP     = 3'd4;
    localparam logic [2:0] EV_LCLICK = 3'd5;
    localparam logic [2:0] EV_RCLICK = 3'd6;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] tick_now;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic signed [31:0] cursor_x;
        logic signed [31:0] cursor_y;
        logic [2:0]         button_bits;
        logic signed [7:0]  wheel_delta;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  device_id;
        logic [15:0] move_gap_ticks;
        logic [15:0] click_window_ticks;
    } cfg_t;

    // header_bits: yof, xof, ysgn, xsgn, middle, right, left
    typedef struct packed {
        logic [2:0]  byte_index;
        logic [6:0]  header_bits;
        logic [7:0]  x_byte;
        logic [7:0]  y_byte;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [2:0]  prev_buttons;
        logic        held_flag;
        logic [31:0] down_stamp;
        logic [31:0] move_stamp;
    } state_t;

    // results caused by one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage

FILE: hdl/ps2m_step.sv
// Per-byte decode: packet framing, position update and event classification.
// Pure combinational; depends on ps2m_pkg.
module ps2m_step (
    input  ps2m_pkg::state_t   cur,
    input  ps2m_pkg::cfg_t     cfg,
    input  ps2m_pkg::in_item_t item,
    output ps2m_pkg::state_t   nxt,
    output ps2m_pkg::push_t    push
);

    logic        fin;
    logic [7:0]  wheel;
    logic [7:0]  y_cur;
    logic [2:0]  btns;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic        moved;
    logic        move_early;
    logic        in_window;
    logic        wheel_dev;

    assign wheel_dev  = (cfg.device_id == ps2m_pkg::DEV_WHEEL) ||
                        (cfg.device_id == ps2m_pkg::DEV_WHEEL5);
    assign y_cur      = (cur.byte_index == ps2m_pkg::IDX_Y) ? item.rx_byte : cur.y_byte;
    assign btns       = cur.header_bits[2:0];
    assign dx         = {{24{cur.header_bits[3]}}, cur.x_byte};
    assign dy         = {{24{cur.header_bits[4]}}, y_cur};
    assign new_x      = cur.pos_x + dx;
    assign new_y      = cur.pos_y - dy;
    assign moved      = (dx != 32'd0) || (dy != 32'd0);
    assign move_early = (item.tick_now - cur.move_stamp) < {16'd0, cfg.move_gap_ticks};
    assign in_window  = (item.tick_now - cur.down_stamp) < {16'd0, cfg.click_window_ticks};

    always_comb
    begin
        logic [2:0] kind;
        logic       emit;
        logic       click;

        nxt   = cur;
        push  = '0;
        fin   = 1'b0;
        wheel = 8'd0;
        kind  = ps2m_pkg::EV_NONE;
        emit  = 1'b1;
        click = 1'b0;

        case (cur.byte_index)
            ps2m_pkg::IDX_HEADER:
            begin
                // headers without the always-one bit are skipped to resync
                if (item.rx_byte[3])
                begin
                    nxt.header_bits = {item.rx_byte[7:4], item.rx_byte[2:0]};
                    nxt.byte_index  = ps2m_pkg::IDX_X;
                end
            end
            ps2m_pkg::IDX_X:
            begin
                nxt.x_byte     = item.rx_byte;
                nxt.byte_index = ps2m_pkg::IDX_Y;
            end
            ps2m_pkg::IDX_Y:
            begin
                nxt.y_byte = item.rx_byte;
                if (cfg.device_id == ps2m_pkg::DEV_STANDARD)
                begin
                    fin            = 1'b1;
                    nxt.byte_index = ps2m_pkg::IDX_HEADER;
                end
                else
                begin
                    nxt.byte_index = ps2m_pkg::IDX_WHEEL;
                end
            end
            ps2m_pkg::IDX_WHEEL:
            begin
                fin            = wheel_dev;
                wheel          = item.rx_byte;
                nxt.byte_index = ps2m_pkg::IDX_HEADER;
            end
            default:
            begin
                nxt.byte_index = ps2m_pkg::IDX_HEADER;
            end
        endcase

        // overflow packets leave no trace
        if (fin && (cur.header_bits[6:5] == 2'b00))
        begin
            nxt.pos_x = new_x;
            nxt.pos_y = new_y;

            if (wheel != 8'd0)
            begin
                kind = ps2m_pkg::EV_SCROLL;
            end
            else if (moved)
            begin
                if (move_early)
                begin
                    emit = 1'b0;
                end
                else
                begin
                    nxt.move_stamp = item.tick_now;
                    nxt.down_stamp = ps2m_pkg::STAMP_IDLE;
                    kind           = ps2m_pkg::EV_MOVE;
                end
            end
            else if ((btns != 3'd0) && !cur.held_flag)
            begin
                kind           = ps2m_pkg::EV_DOWN;
                nxt.down_stamp = item.tick_now;
                nxt.held_flag  = 1'b1;
            end
            else if (in_window && cur.held_flag)
            begin
                // still packet soon after press, buttons released or not: an up item, then the click item
                click          = 1'b1;
                nxt.held_flag  = 1'b0;
                nxt.down_stamp = ps2m_pkg::STAMP_IDLE;
                if (cur.prev_buttons[0])
                    kind = ps2m_pkg::EV_LCLICK;
                else if (cur.prev_buttons[1])
                    kind = ps2m_pkg::EV_RCLICK;
            end
            else if (cur.held_flag && (btns == 3'd0))
            begin
                kind           = ps2m_pkg::EV_UP;
                nxt.held_flag  = 1'b0;
                nxt.down_stamp = ps2m_pkg::STAMP_IDLE;
            end

            if (emit)
            begin
                nxt.prev_buttons = btns;

                push.first.cursor_x    = new_x;
                push.first.cursor_y    = new_y;
                push.first.button_bits = btns;
                push.second            = push.first;

                if (click)
                begin
                    push.count              = 2'd2;
                    push.first.event_kind   = ps2m_pkg::EV_UP;
                    push.first.wheel_delta  = 8'sd0;
                    push.first.last_of_run  = 1'b0;
                    push.second.event_kind  = kind;
                    push.second.wheel_delta = 8'sd0;
                    push.second.last_of_run = 1'b1;
                end
                else
                begin
                    push.count             = 2'd1;
                    push.first.event_kind  = kind;
                    push.first.wheel_delta = (kind == ps2m_pkg::EV_SCROLL) ? wheel : 8'd0;
                    push.first.last_of_run = 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/ps2m_rq.sv
// Four-entry result queue; takes up to two items per cycle, hands out one.
// Depends on ps2m_pkg.
module ps2m_rq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  ps2m_pkg::push_t     push,
    output logic                room,
    output logic                event_valid,
    input  logic                event_ready,
    output ps2m_pkg::out_item_t event_item
);

    ps2m_pkg::out_item_t entry_reg [4];
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] wr_ptr_reg;
    logic [1:0] push_n;
    logic       pop;

    assign push_n      = push_en ? push.count : 2'd0;
    assign room        = (count_reg <= 3'd2);
    assign event_valid = (count_reg != 3'd0);
    assign event_item  = entry_reg[rd_ptr_reg];
    assign pop         = event_valid && event_ready;
    assign count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 3'd0;
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push_n == 2'd2)
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
    end

endmodule

FILE: hdl/ps2_mouse_packet_event_decoder_core.sv
// Top level of the PS/2 mouse packet event decoder: state and config registers.
// Depends on ps2m_pkg, ps2m_step and ps2m_rq.
//
// Bytes from the mouse data port enter on byte_valid/byte_ready with a tick
// stamp in byte_item. Decoded events leave on event_valid/event_ready in
// event_item; a byte gives zero, one or two events, the last one flagged.
// A byte is taken in the cycle it is offered as long as the four-entry result
// queue has room for two more items; with the receiver taking items, one byte
// per cycle is sustained. The events of the byte that completes a packet are
// registered in the result queue when that byte is accepted.
// When the receiver stalls, results collect in the queue and byte_ready drops
// once fewer than two slots are free; nothing is lost.
// Config registers are written through cfg_we/cfg_index/cfg_data, one per
// cycle, only while the block is idle; the user must ensure this, not the block.
// Reset (rst_n low, asynchronous) empties the queue, restarts packet framing,
// centers the cursor and loads the default move gap and click window.
module ps2_mouse_packet_event_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  ps2m_pkg::in_item_t  byte_item,
    output logic                event_valid,
    input  logic                event_ready,
    output ps2m_pkg::out_item_t event_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    ps2m_pkg::state_t state_reg;
    ps2m_pkg::state_t state_next;
    ps2m_pkg::cfg_t   cfg_reg;
    ps2m_pkg::push_t  push;
    logic             byte_accept;

    assign byte_accept = byte_valid && byte_ready;

    ps2m_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (byte_item),
        .nxt  (state_next),
        .push (push)
    );

    ps2m_rq u_rq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_en     (byte_accept),
        .push        (push),
        .room        (byte_ready),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_item  (event_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.byte_index   <= ps2m_pkg::IDX_HEADER;
            state_reg.header_bits  <= 7'd0;
            state_reg.x_byte       <= 8'd0;
            state_reg.y_byte       <= 8'd0;
            state_reg.pos_x        <= ps2m_pkg::POS_X_RESET;
            state_reg.pos_y        <= ps2m_pkg::POS_Y_RESET;
            state_reg.prev_buttons <= 3'd0;
            state_reg.held_flag    <= 1'b0;
            state_reg.down_stamp   <= ps2m_pkg::STAMP_IDLE;
            state_reg.move_stamp   <= 32'd0;
        end
        else if (byte_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id          <= ps2m_pkg::DEV_STANDARD;
            cfg_reg.move_gap_ticks     <= ps2m_pkg::MOVE_GAP_RESET;
            cfg_reg.click_window_ticks <= ps2m_pkg::CLICK_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ps2m_pkg::REG_DEVICE_ID:    cfg_reg.device_id          <= cfg_data[7:0];
                ps2m_pkg::REG_MOVE_GAP:     cfg_reg.move_gap_ticks     <= cfg_data;
                ps2m_pkg::REG_CLICK_WINDOW: cfg_reg.click_window_ticks <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // framing never reaches an index past the wheel byte
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_index <= ps2m_pkg::IDX_WHEEL)
        else $error("packet byte index out of range");

    // a fourth byte on a device without a wheel ends the packet silently
    a_no_wheel_silent: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && (state_reg.byte_index == ps2m_pkg::IDX_WHEEL) &&
        (cfg_reg.device_id != ps2m_pkg::DEV_WHEEL) &&
        (cfg_reg.device_id != ps2m_pkg::DEV_WHEEL5) |-> (push.count == 2'd0))
        else $error("result from a non-wheel fourth byte");

    // a two-item run is an up followed by the flagged click item
    a_click_pair: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && (push.count == 2'd2) |->
        (push.first.event_kind == ps2m_pkg::EV_UP) && !push.first.last_of_run &&
        push.second.last_of_run)
        else $error("malformed click pair");

    // input back-pressure only comes from queued results
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> event_valid)
        else $error("byte_ready low with empty result queue");

endmodule
